[rtl/core/pgrr_pkg.sv]
// shared types and constants for the pixel grid rectangle and rotate core
package pgrr_pkg;

	localparam int DEF_WIDTH  = 64;
	localparam int DEF_HEIGHT = 8;

	localparam int OP_W          = 2;
	localparam int FILL_WIDTH_W  = 7;
	localparam int FILL_HEIGHT_W = 4;
	localparam int LINE_W        = 6;
	localparam int SHIFT_W       = 6;
	localparam int COUNT_W       = 10;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;

	localparam logic [OP_W-1:0] OP_FILL    = 2'd0;
	localparam logic [OP_W-1:0] OP_ROT_ROW = 2'd1;
	localparam logic [OP_W-1:0] OP_ROT_COL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [FILL_WIDTH_W-1:0]  fill_width;
		logic [FILL_HEIGHT_W-1:0] fill_height;
		logic [LINE_W-1:0]        line_index;
		logic [SHIFT_W-1:0]       shift_amount;
	} cmd_t;

endpackage

[rtl/core/pgrr_grid.sv]
// pixel grid state register with combinational fill, row rotate and column rotate
module pgrr_grid import pgrr_pkg::*; #(
	parameter int WIDTH  = DEF_WIDTH,
	parameter int HEIGHT = DEF_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  cmd_t                          cmd,
	output logic [HEIGHT-1:0][WIDTH-1:0]  grid,
	output logic                          grid_valid,
	input  logic                          grid_ready
);

	logic [HEIGHT-1:0][WIDTH-1:0] grid_q;
	logic [HEIGHT-1:0][WIDTH-1:0] grid_d;
	logic                         done_q;
	logic                         apply;

	logic [WIDTH-1:0]  row_sel;
	logic [WIDTH-1:0]  col_hit;
	logic [WIDTH-1:0]  fill_mask;
	logic [HEIGHT-1:0] col_sel;
	logic [WIDTH-1:0]  row_rot [SHIFT_W+1];
	logic [HEIGHT-1:0] col_rot [SHIFT_W+1];

	assign cmd_ready  = !done_q || grid_ready;
	assign apply      = cmd_valid && cmd_ready;
	assign grid       = grid_q;
	assign grid_valid = done_q;

	// column decode and fill mask
	always_comb begin
		for (int c = 0; c < WIDTH; c++) begin
			col_hit[c]   = (cmd.line_index == LINE_W'(c));
			fill_mask[c] = (cmd.fill_width > FILL_WIDTH_W'(c));
		end
	end

	// pick the addressed row and gather the addressed column
	always_comb begin
		row_sel = '0;
		for (int r = 0; r < HEIGHT; r++) begin
			if (cmd.line_index == LINE_W'(r)) begin
				row_sel = grid_q[r];
			end
			col_sel[r] = |(grid_q[r] & col_hit);
		end
	end

	assign row_rot[0] = row_sel;
	assign col_rot[0] = col_sel;

	// log-step rotators, each step a fixed rotation by 2^i reduced to the line length
	for (genvar i = 0; i < SHIFT_W; i++) begin : g_rot
		localparam int KR = (2 ** i) % WIDTH;
		localparam int KC = (2 ** i) % HEIGHT;
		logic [2*WIDTH-1:0]  row_dbl;
		logic [2*HEIGHT-1:0] col_dbl;
		assign row_dbl = {row_rot[i], row_rot[i]};
		assign col_dbl = {col_rot[i], col_rot[i]};
		assign row_rot[i+1] = cmd.shift_amount[i] ? row_dbl[2*WIDTH-1-KR -: WIDTH] : row_rot[i];
		assign col_rot[i+1] = cmd.shift_amount[i] ? col_dbl[2*HEIGHT-1-KC -: HEIGHT] : col_rot[i];
	end

	always_comb begin
		grid_d = grid_q;
		case (cmd.operation)
			OP_FILL: begin
				for (int r = 0; r < HEIGHT; r++) begin
					if (cmd.fill_height > FILL_HEIGHT_W'(r)) begin
						grid_d[r] = grid_q[r] | fill_mask;
					end
				end
			end
			OP_ROT_ROW: begin
				for (int r = 0; r < HEIGHT; r++) begin
					if (cmd.line_index == LINE_W'(r)) begin
						grid_d[r] = row_rot[SHIFT_W];
					end
				end
			end
			OP_ROT_COL: begin
				for (int r = 0; r < HEIGHT; r++) begin
					grid_d[r] = (grid_q[r] & ~col_hit) | (col_rot[SHIFT_W][r] ? col_hit : '0);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (apply) begin
				grid_q <= grid_d;
			end
			if (cmd_ready) begin
				done_q <= cmd_valid;
			end
		end
	end

endmodule

[rtl/core/pgrr_count.sv]
// pipelined lit pixel count: byte counts, row sums, grid total
module pgrr_count import pgrr_pkg::*; #(
	parameter int WIDTH  = DEF_WIDTH,
	parameter int HEIGHT = DEF_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [HEIGHT-1:0][WIDTH-1:0]  grid,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic [COUNT_W-1:0]            lit_count,
	output logic                          out_valid,
	input  logic                          out_ready
);

	localparam int CHUNKS  = (WIDTH + 7) / 8;
	localparam int PAD_W   = CHUNKS * 8;
	localparam int CHUNK_W = 4;
	localparam int ROW_W   = $clog2(WIDTH + 1);

	logic [CHUNK_W-1:0] chunk_d  [HEIGHT][CHUNKS];
	logic [CHUNK_W-1:0] chunk_s3 [HEIGHT][CHUNKS];
	logic [ROW_W-1:0]   row_d    [HEIGHT];
	logic [ROW_W-1:0]   row_s4   [HEIGHT];
	logic [COUNT_W-1:0] total_d;
	logic [COUNT_W-1:0] lit_count_q;

	logic valid_s3, valid_s4, out_valid_q;
	logic ready_s4, ready_out;

	assign ready_out = !out_valid_q || out_ready;
	assign ready_s4  = !valid_s4 || ready_out;
	assign in_ready  = !valid_s3 || ready_s4;

	assign lit_count = lit_count_q;
	assign out_valid = out_valid_q;

	always_comb begin
		logic [PAD_W-1:0] row_pad;
		for (int r = 0; r < HEIGHT; r++) begin
			row_pad = PAD_W'(grid[r]);
			for (int k = 0; k < CHUNKS; k++) begin
				chunk_d[r][k] = '0;
				for (int b = 0; b < 8; b++) begin
					chunk_d[r][k] = chunk_d[r][k] + CHUNK_W'(row_pad[k*8+b]);
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < HEIGHT; r++) begin
			row_d[r] = '0;
			for (int k = 0; k < CHUNKS; k++) begin
				row_d[r] = row_d[r] + ROW_W'(chunk_s3[r][k]);
			end
		end
	end

	always_comb begin
		total_d = '0;
		for (int r = 0; r < HEIGHT; r++) begin
			total_d = total_d + COUNT_W'(row_s4[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			chunk_s3 <= chunk_d;
		end
		if (valid_s3 && ready_s4) begin
			row_s4 <= row_d;
		end
		if (valid_s4 && ready_out) begin
			lit_count_q <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_out) begin
				out_valid_q <= valid_s4;
			end
		end
	end

endmodule

[rtl/core/pixel_grid_rect_rotate_core.sv]
// top level of the pixel grid rectangle fill and row/column rotate core
// Keeps a WIDTH x HEIGHT one-bit pixel grid, dark after reset, and takes one command per
// beat: fill the top-left rectangle (clamped to the grid), rotate one row right or rotate
// one column down (shift taken modulo the line length, out-of-grid index ignored). Every
// command returns one beat holding the number of lit pixels after it. A command is taken
// every cycle while the output is not stalled: the grid update for one command is written
// straight into the grid register, which sets the rate. Results pass an input register, the
// grid update and a three-stage count pipeline; each stage holds under backpressure, so up
// to five commands can be in flight.
module pixel_grid_rect_rotate_core import pgrr_pkg::*; #(
	parameter int WIDTH  = DEF_WIDTH,
	parameter int HEIGHT = DEF_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // fill_width, fill_height, line_index, shift_amount
	input  logic [S_TUSER_W-1:0] s_tuser,  // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // lit_count
);

	cmd_t                         cmd_s1;
	logic                         valid_s1;
	logic                         cmd_ready;
	logic [HEIGHT-1:0][WIDTH-1:0] grid;
	logic                         grid_valid;
	logic                         grid_ready;
	logic [COUNT_W-1:0]           lit_count;

	assign s_tready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.operation    <= s_tuser[OP_W-1:0];
			cmd_s1.fill_width   <= s_tdata[6:0];
			cmd_s1.fill_height  <= s_tdata[10:7];
			cmd_s1.line_index   <= s_tdata[16:11];
			cmd_s1.shift_amount <= s_tdata[22:17];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	pgrr_grid #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_grid (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (valid_s1),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd_s1),
		.grid       (grid),
		.grid_valid (grid_valid),
		.grid_ready (grid_ready)
	);

	pgrr_count #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid      (grid),
		.in_valid  (grid_valid),
		.in_ready  (grid_ready),
		.lit_count (lit_count),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	assign m_tdata = {{(M_TDATA_W-COUNT_W){1'b0}}, lit_count};

	// grid only moves on an applied command
	a_grid_moves_on_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(grid) |-> $past(valid_s1 && cmd_ready))
		else $error("grid changed without an applied command");

	// grid held while its count has not been sampled
	a_grid_held_for_count: assert property (@(posedge clk) disable iff (!arst_n)
		(grid_valid && !grid_ready) |=> $stable(grid))
		else $error("grid changed before its count was taken");

	// count never exceeds the grid size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (lit_count <= COUNT_W'(WIDTH * HEIGHT)))
		else $error("lit count above grid size");

endmodule
